>>> design/sws_pkg.sv
// Package for the stack with search: action, status and cell operation codes,
// field widths and the control struct that drives the row of stack cells.
// No dependencies.
`timescale 1ns / 1ps

package sws_pkg;

    localparam int ACTION_W = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

    // Operations broadcast to every cell.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_PUSH = 2'd1;
    localparam logic [1:0] CELL_POP  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0] op;
    } cell_ctrl_t;

endpackage

>>> design/sws_cell.sv
// One cell of the stack: holds a single word and moves it to a neighbour on
// push, pop or rotate. Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_cell
    import sws_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       wrap_here,
    input  word_t      above,
    input  word_t      below,
    input  word_t      top,
    output word_t      q
);

    word_t data_reg;
    word_t data_next;

    // On a rotation the deepest occupied cell takes the top word, so the
    // occupied part of the row turns round by one place.
    always_comb
    begin
        case (ctrl.op)
            CELL_PUSH: data_next = above;
            CELL_POP:  data_next = below;
            CELL_ROT:  data_next = wrap_here ? top : below;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

>>> design/stack_with_search_unit.sv
// Top level of the stack with search: a row of sws_cell instances with the top
// at cell 0, a small sequencer and an output register. Depends on sws_pkg, sws_cell.
//
//  channel | signals                      | direction | contents
//  s       | s_tvalid s_tready s_tdata    | in        | action, value
//  m       | m_tvalid m_tready m_tdata    | out       | status, word
//          | m_tlast                      |           | last result of an item
//
// Push and pop are each handled as the item is taken. Search rotates the occupied
// cells once round, one cell per cycle, the last step waiting for a free output register.
// Display gives one result per cycle while m_tready is high.
// A new item is taken only when the sequencer is idle and the output register
// is free or being emptied. Reset empties the stack; the cells are not cleared.
`timescale 1ns / 1ps

module stack_with_search_unit
    import sws_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // action [1:0], value [33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // status [2:0], word [34:3], zero pad
    output logic        m_tlast
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       step_reg, step_next;
    word_t               key_reg, key_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    word_t               out_word_reg, out_word_next;
    logic                out_last_reg, out_last_next;

    logic [ACTION_W-1:0] in_action;
    word_t               in_value;
    logic                in_fire;
    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic                match;
    cell_ctrl_t          ctrl;
    word_t               cell_q [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] wrap_here;

    assign in_action = s_tdata[1:0];
    assign in_value  = s_tdata[33:2];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign is_full   = (count_reg == CW'(STACK_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign match     = (cell_q[0] == key_reg);

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            word_t above_w;
            word_t below_w;

            if (i == 0)
            begin : g_top
                assign above_w = in_value;
            end
            else
            begin : g_mid
                assign above_w = cell_q[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_bot
                assign below_w = '0;
            end
            else
            begin : g_up
                assign below_w = cell_q[i+1];
            end

            assign wrap_here[i] = (count_reg == CW'(i + 1));

            sws_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .wrap_here (wrap_here[i]),
                .above     (above_w),
                .below     (below_w),
                .top       (cell_q[0]),
                .q         (cell_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        ctrl.op         = CELL_HOLD;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_word_next = '0;
                    out_last_next = 1'b1;
                    case (in_action)
                        ACT_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = STS_FULL;
                            end
                            else
                            begin
                                out_status_next = STS_OK;
                                ctrl.op         = CELL_PUSH;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            out_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                out_status_next = STS_EMPTY;
                            end
                            else
                            begin
                                out_status_next = STS_OK;
                                out_word_next   = cell_q[0];
                                ctrl.op         = CELL_POP;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STS_EMPTY;
                            end
                            else
                            begin
                                step_next  = count_reg;
                                key_next   = in_value;
                                hit_next   = 1'b0;
                                state_next = (in_action == ACT_SEARCH) ? S_SCAN : S_SHOW;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // The last compare also delivers the result, so it waits for room.
                if (step_reg != CW'(1) || out_free)
                begin
                    ctrl.op   = CELL_ROT;
                    step_next = step_reg - 1'b1;
                    hit_next  = hit_reg || match;
                    if (step_reg == CW'(1))
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (hit_reg || match)
                        begin
                            // A hit word always equals the key.
                            out_status_next = STS_FOUND;
                            out_word_next   = key_reg;
                        end
                        else
                        begin
                            out_status_next = STS_NOTFOUND;
                            out_word_next   = '0;
                        end
                    end
                end
            end
            S_SHOW:
            begin
                if (out_free)
                begin
                    ctrl.op         = CELL_ROT;
                    step_next       = step_reg - 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = STS_OK;
                    out_word_next   = cell_q[0];
                    out_last_next   = (step_reg == CW'(1));
                    if (step_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        key_reg        <= key_next;
        hit_reg        <= hit_next;
        out_status_reg <= out_status_next;
        out_word_reg   <= out_word_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_word_reg, out_status_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack fill count beyond depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_action == ACT_POP && !is_empty
        |=> count_reg == CW'($past(count_reg) - 1'b1))
        else $error("pop did not remove one word");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !is_empty && step_reg != '0)
        else $error("walk running over an empty stack");

    a_midframe_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> out_status_reg == STS_OK)
        else $error("non-final result with a status other than ok");
`endif

endmodule

>>> tb/tb_stack_with_search_unit.sv
// Testbench for stack_with_search_unit. A scoreboard object models the stack,
// predicts every result item and checks each one the block delivers, in order.
// Depends on sws_pkg and the stack_with_search_unit RTL.
`timescale 1ns / 1ps

module tb_stack_with_search_unit;
    import sws_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 430;
    localparam int IDLE_PERCENT = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // action [1:0], value [33:2], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status [2:0], word [34:3], zero pad
    logic        m_tlast;

    bit          no_idle = 1'b0;
    int unsigned cycle_count = 0;

    typedef struct {
        logic [STATUS_W-1:0] status;
        word_t               word;
        logic                last;
    } stack_result_t;

    class stack_scoreboard;
        word_t         contents [STACK_DEPTH];
        int            fill;
        stack_result_t results_due [$];
        int unsigned   mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void add_result(logic [STATUS_W-1:0] status, word_t word, logic last);
            stack_result_t r;
            r.status = status;
            r.word   = word;
            r.last   = last;
            results_due.push_back(r);
        endfunction

        // Works out the result items that one accepted input item causes.
        function void note_item(logic [ACTION_W-1:0] action, word_t value);
            int i;
            bit hit;
            case (action)
                ACT_PUSH:
                    if (fill == STACK_DEPTH)
                        add_result(STS_FULL, '0, 1'b1);
                    else
                    begin
                        contents[fill] = value;
                        fill++;
                        add_result(STS_OK, '0, 1'b1);
                    end
                ACT_POP:
                    if (fill == 0)
                        add_result(STS_EMPTY, '0, 1'b1);
                    else
                    begin
                        fill--;
                        add_result(STS_OK, contents[fill], 1'b1);
                    end
                ACT_SEARCH:
                    if (fill == 0)
                        add_result(STS_EMPTY, '0, 1'b1);
                    else
                    begin
                        // The topmost match wins when the key is stored more than once.
                        hit = 1'b0;
                        for (i = fill - 1; i >= 0 && !hit; i--)
                        begin
                            if (contents[i] == value)
                            begin
                                hit = 1'b1;
                                add_result(STS_FOUND, contents[i], 1'b1);
                            end
                        end
                        if (!hit)
                            add_result(STS_NOTFOUND, '0, 1'b1);
                    end
                default:
                    if (fill == 0)
                        add_result(STS_EMPTY, '0, 1'b1);
                    else
                        for (i = fill - 1; i >= 0; i--)
                            add_result(STS_OK, contents[i], i == 0);
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [STATUS_W-1:0] status, word_t word, logic last);
            stack_result_t due;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item: status %0d word %0d last %0b",
                                          status, word, last));
                return;
            end
            due = results_due.pop_front();
            if (status !== due.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, due.status));
            if (word !== due.word)
                report_mismatch($sformatf("word %0d, expected %0d", word, due.word));
            if (last !== due.last)
                report_mismatch($sformatf("last %0b, expected %0b", last, due.last));
        endtask
    endclass

    stack_scoreboard sb = new();

    stack_with_search_unit #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check what was taken at this edge, then choose the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[2:0], m_tdata[34:3], m_tlast);
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic send_item(input logic [ACTION_W-1:0] action, input word_t value);
        s_tdata  <= {6'b0, value, action};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(action, value);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.results_due.size() != 0)
            @(posedge clk);
    endtask

    // Mostly full-range words, with extremes and a narrow band that breeds duplicates.
    function automatic word_t pick_word();
        case ($urandom_range(9))
            0:
                case ($urandom_range(3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return '0;
                    default: return '1;
                endcase
            1, 2, 3: return word_t'($urandom_range(7));
            default: return word_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int n;
        int i;
        int push_bias;
        int r;
        int bias_set [4];
        word_t key;

        bias_set = '{85, 30, 60, 15};
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Every read action on an empty stack.
        send_item(ACT_POP, 32'sd9);
        send_item(ACT_SEARCH, 32'sd0);
        send_item(ACT_DISPLAY, '1);
        send_item(ACT_PUSH, 32'sh7fff_ffff);
        send_item(ACT_PUSH, 32'sh8000_0000);
        send_item(ACT_PUSH, '0);
        send_item(ACT_PUSH, '1);
        send_item(ACT_PUSH, 32'sh7fff_ffff);
        send_item(ACT_SEARCH, 32'sh7fff_ffff);
        send_item(ACT_SEARCH, 32'sd5);
        send_item(ACT_DISPLAY, '0);
        // Fill to the top, then push once more onto the full stack.
        for (i = 0; i < STACK_DEPTH - 5; i++)
            send_item(ACT_PUSH, word_t'($urandom));
        send_item(ACT_PUSH, 32'sd77);
        send_item(ACT_SEARCH, 32'sh8000_0000);
        send_item(ACT_POP, '0);
        wait_drained();

        push_bias = bias_set[0];
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                push_bias = bias_set[(n / 60) % 4];
            no_idle = (n >= 150 && n < 250);
            if (n == 300)
                wait_drained();
            r = $urandom_range(99);
            if (r < push_bias)
                send_item(ACT_PUSH, pick_word());
            else
            begin
                r = $urandom_range(99);
                if (r < 50)
                    send_item(ACT_POP, pick_word());
                else if (r < 85)
                begin
                    if (sb.fill > 0 && $urandom_range(1))
                        key = sb.contents[$urandom_range(sb.fill - 1)];
                    else
                        key = pick_word();
                    send_item(ACT_SEARCH, key);
                end
                else
                    send_item(ACT_DISPLAY, pick_word());
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (2 * STACK_DEPTH + 8) @(posedge clk);
        if (sb.mismatches == 0 && sb.results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> stack_with_search_unit.f
design/sws_pkg.sv
design/sws_cell.sv
design/stack_with_search_unit.sv
tb/tb_stack_with_search_unit.sv
